// File: design/ptw_pkg.sv
`timescale 1ns / 1ps
package ptw_pkg;

	// walk_mode codes
	localparam logic [1:0] MODE_LONG  = 2'd0;
	localparam logic [1:0] MODE_SHORT = 2'd1;

	// input kind codes
	localparam logic KIND_REQUEST  = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;

	// result kind and entry size codes
	localparam logic RESULT_READ = 1'b0;
	localparam logic RESULT_DONE = 1'b1;
	localparam logic SIZE_8      = 1'b0;
	localparam logic SIZE_4      = 1'b1;

	localparam logic [1:0] WALK_MODE_RESET = 2'd2;

	localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] BASE_1G   = 64'h000F_FFFF_C000_0000;
	localparam logic [63:0] BASE_2M   = 64'h000F_FFFF_FFE0_0000;
	localparam logic [63:0] OFFS_1G   = 64'h0000_0000_3FFF_FFFF;
	localparam logic [63:0] OFFS_2M   = 64'h0000_0000_001F_FFFF;
	localparam logic [63:0] OFFS_4K   = 64'h0000_0000_0000_0FFF;
	localparam logic [31:0] BASE32    = 32'hFFFF_F000;
	localparam logic [16:0] CANON_HIGH = 17'h1FFFF;

	localparam int BIT_P  = 0;
	localparam int BIT_PS = 7;

	// classified item passed from front to back
	typedef struct packed {
		logic        is_req;
		logic        start_short;
		logic        fallback;
		logic        canon_ok;
		logic [63:0] va;
		logic [63:0] root;
		logic [63:0] entry;
		logic        failed;
	} ptw_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] entry_address;
		logic        entry_size;
		logic [63:0] physical_address;
		logic        fault;
	} ptw_result_t;

endpackage

// File: design/ptw_front.sv
`timescale 1ns / 1ps
module ptw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 kind,
	input  logic [63:0]          virtual_address,
	input  logic [63:0]          table_root,
	input  logic [63:0]          entry_data,
	input  logic                 read_failed,
	output ptw_pkg::ptw_item_t   item
);

	logic [1:0]  walk_mode_q;
	logic [16:0] top_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q <= ptw_pkg::WALK_MODE_RESET;
		end else if (cfg_we) begin
			walk_mode_q <= cfg_wdata;
		end
	end

	assign top_bits = virtual_address[63:47];

	// classify: decode mode at request time and check the address form
	always_comb begin
		item.is_req      = (kind == ptw_pkg::KIND_REQUEST);
		item.start_short = (walk_mode_q == ptw_pkg::MODE_SHORT);
		item.fallback    = (walk_mode_q != ptw_pkg::MODE_LONG);
		item.canon_ok    = (top_bits == 17'd0) || (top_bits == ptw_pkg::CANON_HIGH);
		item.va          = virtual_address;
		item.root        = table_root;
		item.entry       = entry_data;
		item.failed      = read_failed;
	end

endmodule

// File: design/ptw_queue.sv
`timescale 1ns / 1ps
module ptw_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ptw_pkg::ptw_item_t   push_item,
	input  logic                 pop,
	output logic                 empty,
	output logic                 full,
	output ptw_pkg::ptw_item_t   head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	ptw_pkg::ptw_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/ptw_back.sv
`timescale 1ns / 1ps
module ptw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  ptw_pkg::ptw_item_t   q_head,
	output logic                 q_pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output ptw_pkg::ptw_result_t res
);

	logic        busy_q;
	logic [1:0]  level_q;
	logic        short_q;
	logic        fallback_q;
	logic [63:0] held_va_q;
	logic [63:0] held_root_q;
	logic        out_valid_q;
	ptw_pkg::ptw_result_t res_q;

	logic        out_ready;
	logic        nxt_busy;
	logic [1:0]  nxt_level;
	logic        nxt_short;
	logic        nxt_fallback;
	logic        emit;
	logic        go_read;
	logic        go_short;
	logic        go_fault;
	logic        go_done;
	logic        fail_long;
	logic        bad_entry;
	logic [63:0] cur_va;
	logic [63:0] cur_root;
	logic [31:0] e32;
	logic [63:0] rd_base;
	logic [11:0] rd_off;
	logic        rd_size;
	logic [63:0] done_pa;
	ptw_pkg::ptw_result_t res_next;

	assign out_ready = !out_valid_q || !out_stall;
	assign q_pop     = !q_empty && out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign cur_va   = q_head.is_req ? q_head.va : held_va_q;
	assign cur_root = q_head.is_req ? q_head.root : held_root_q;
	assign e32      = q_head.entry[31:0];
	assign bad_entry = q_head.failed || !q_head.entry[ptw_pkg::BIT_P];

	always_comb begin
		nxt_busy     = busy_q;
		nxt_level    = level_q;
		nxt_short    = short_q;
		nxt_fallback = fallback_q;
		go_read      = 1'b0;
		go_short     = 1'b0;
		go_fault     = 1'b0;
		go_done      = 1'b0;
		fail_long    = 1'b0;
		rd_base      = '0;
		rd_off       = '0;
		rd_size      = ptw_pkg::SIZE_8;
		done_pa      = '0;

		if (q_pop) begin
			priority if (q_head.is_req) begin
				if (q_head.start_short) begin
					go_short = 1'b1;
				end else begin
					nxt_fallback = q_head.fallback;
					if (!q_head.canon_ok) begin
						fail_long = 1'b1;
					end else begin
						// first long read from the table root
						go_read   = 1'b1;
						nxt_busy  = 1'b1;
						nxt_short = 1'b0;
						nxt_level = 2'd0;
						rd_base   = cur_root & ptw_pkg::ADDR_MASK;
						rd_off    = {cur_va[47:39], 3'b000};
					end
				end
			end else if (!busy_q) begin
				// drop stray response
			end else if (short_q) begin
				if (q_head.failed || !e32[ptw_pkg::BIT_P]) begin
					go_fault = 1'b1;
				end else if (level_q == 2'd0) begin
					go_read   = 1'b1;
					nxt_level = 2'd1;
					rd_base   = {32'd0, e32 & ptw_pkg::BASE32};
					rd_off    = {cur_va[21:12], 2'b00};
					rd_size   = ptw_pkg::SIZE_4;
				end else begin
					go_done = 1'b1;
					done_pa = {32'd0, e32 & ptw_pkg::BASE32} |
						(cur_va & ptw_pkg::OFFS_4K);
				end
			end else if (bad_entry) begin
				fail_long = 1'b1;
			end else begin
				unique case (level_q)
					2'd0: begin
						go_read   = 1'b1;
						nxt_level = 2'd1;
						rd_base   = q_head.entry & ptw_pkg::ADDR_MASK;
						rd_off    = {cur_va[38:30], 3'b000};
					end
					2'd1: begin
						if (q_head.entry[ptw_pkg::BIT_PS]) begin
							go_done = 1'b1;
							done_pa = (q_head.entry & ptw_pkg::BASE_1G) |
								(cur_va & ptw_pkg::OFFS_1G);
						end else begin
							go_read   = 1'b1;
							nxt_level = 2'd2;
							rd_base   = q_head.entry & ptw_pkg::ADDR_MASK;
							rd_off    = {cur_va[29:21], 3'b000};
						end
					end
					2'd2: begin
						if (q_head.entry[ptw_pkg::BIT_PS]) begin
							go_done = 1'b1;
							done_pa = (q_head.entry & ptw_pkg::BASE_2M) |
								(cur_va & ptw_pkg::OFFS_2M);
						end else begin
							go_read   = 1'b1;
							nxt_level = 2'd3;
							rd_base   = q_head.entry & ptw_pkg::ADDR_MASK;
							rd_off    = {cur_va[20:12], 3'b000};
						end
					end
					default: begin
						go_done = 1'b1;
						done_pa = (q_head.entry & ptw_pkg::ADDR_MASK) |
							(cur_va & ptw_pkg::OFFS_4K);
					end
				endcase
			end

			// a long-walk fault falls back to the short walk when allowed
			if (fail_long) begin
				if (q_head.is_req ? q_head.fallback : fallback_q) begin
					go_short = 1'b1;
				end else begin
					go_fault = 1'b1;
				end
			end

			if (go_short) begin
				go_read      = 1'b1;
				nxt_busy     = 1'b1;
				nxt_short    = 1'b1;
				nxt_fallback = 1'b0;
				nxt_level    = 2'd0;
				rd_base      = {32'd0, cur_root[31:0] & ptw_pkg::BASE32};
				rd_off       = {cur_va[31:22], 2'b00};
				rd_size      = ptw_pkg::SIZE_4;
			end
			if (go_fault) begin
				nxt_fallback = 1'b0;
			end
			if (go_fault || go_done) begin
				nxt_busy  = 1'b0;
				nxt_level = 2'd0;
			end
		end
	end

	assign emit = go_read || go_fault || go_done;

	always_comb begin
		res_next = '0;
		if (go_read) begin
			res_next.result_kind   = ptw_pkg::RESULT_READ;
			res_next.entry_address = rd_base + {52'd0, rd_off};
			res_next.entry_size    = rd_size;
		end else begin
			res_next.result_kind      = ptw_pkg::RESULT_DONE;
			res_next.physical_address = go_fault ? 64'd0 : done_pa;
			res_next.fault            = go_fault;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.is_req) begin
			held_va_q   <= q_head.va;
			held_root_q <= q_head.root;
		end
		if (out_ready && emit) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= 2'd0;
			short_q     <= 1'b0;
			fallback_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q     <= nxt_busy;
			level_q    <= nxt_level;
			short_q    <= nxt_short;
			fallback_q <= nxt_fallback;
			if (out_ready) begin
				out_valid_q <= emit;
			end
		end
	end

endmodule

// File: design/page_table_walker.sv
`timescale 1ns / 1ps
// Page table walker for four-level 64-bit and two-level 32-bit tables.
// Input channel (in_valid / in_stall): kind 0 starts a translation from
// virtual_address and table_root; kind 1 returns an entry read with
// entry_data and read_failed. A transfer happens when in_valid is high and
// in_stall is low. Each transfer yields at most one result.
// Output channel (out_valid / out_stall): result_kind 0 asks for an entry
// read at entry_address (entry_size 0 = 8 bytes, 1 = 4 bytes); result_kind
// 1 ends the walk with physical_address, or fault set and address 0.
// Configuration: cfg_we writes walk_mode from cfg_wdata (0 long, 1 short,
// 2 or 3 long with short fallback); write it only while the walker is idle.
// Timing: the front classifies an item and pushes it into a small queue in
// the transfer cycle; the back pops one item a cycle, unless the output
// stalls, and registers its result, so one item per cycle is sustained;
// a result passes the queue and then the result register. The back's single
// state update per item sets that rate. When out_stall holds, the result
// register holds, the queue fills and in_stall rises once it is full.
// Reset clears the walk state and the queue and sets walk_mode to 2.
module page_table_walker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [63:0] virtual_address,
	input  logic [63:0] table_root,
	input  logic [63:0] entry_data,
	input  logic        read_failed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [63:0] entry_address,
	output logic        entry_size,
	output logic [63:0] physical_address,
	output logic        fault
);

	ptw_pkg::ptw_item_t   front_item;
	ptw_pkg::ptw_item_t   q_head;
	ptw_pkg::ptw_result_t res;
	logic                 q_empty;
	logic                 q_full;
	logic                 q_pop;
	logic                 push;

	// advance an input transfer straight into the queue
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	ptw_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.kind            (kind),
		.virtual_address (virtual_address),
		.table_root      (table_root),
		.entry_data      (entry_data),
		.read_failed     (read_failed),
		.item            (front_item)
	);

	ptw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (q_pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	ptw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	assign result_kind      = res.result_kind;
	assign entry_address    = res.entry_address;
	assign entry_size       = res.entry_size;
	assign physical_address = res.physical_address;
	assign fault            = res.fault;

endmodule
